### src/spc_pkg.sv
// shared types and constants for the 2d shape pair contact block
package spc_pkg;

    localparam logic [2:0] KIND_POINT_CIRCLE  = 3'd0;
    localparam logic [2:0] KIND_CIRCLE_CIRCLE = 3'd1;
    localparam logic [2:0] KIND_POINT_BOX     = 3'd2;
    localparam logic [2:0] KIND_BOX_BOX       = 3'd3;
    localparam logic [2:0] KIND_CIRCLE_BOX    = 3'd4;

    localparam int DW  = 36;
    localparam int UW  = 35;
    localparam int RW  = 36;
    localparam int SW  = 2 * RW + 1;
    localparam int QW  = 15;
    localparam int DV  = RW + QW - 1;
    localparam int HB  = 18;

    localparam logic signed [15:0] NORM_POS = 16'sd16384;
    localparam logic signed [15:0] NORM_NEG = -16'sd16384;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic [30:0]        a_extent_x;
        logic [30:0]        a_extent_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic [30:0]        b_extent_x;
        logic [30:0]        b_extent_y;
    } pair_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [31:0]        depth;
    } contact_t;

    typedef struct packed {
        logic          is_round;
        contact_t      box;
        logic [32:0]   reach;
        logic          sx;
        logic          sy;
        logic [UW-1:0] ux;
        logic [UW-1:0] uy;
    } tag_t;

endpackage

### src/spc_pair_if.sv
// item channel carrying one shape pair
interface spc_pair_if import spc_pkg::*; ();
    logic  valid;
    logic  ready;
    pair_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### src/spc_contact_if.sv
// item channel carrying one contact result
interface spc_contact_if import spc_pkg::*; ();
    logic     valid;
    logic     ready;
    contact_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### src/spc_front.sv
// front stages: bounds, clamp, operand select, box contact
module spc_front import spc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  pair_t in_item,
    output logic  out_valid,
    output tag_t  out_tag
);
    logic signed [DW-1:0] bx_in, by_in, bw_in, bh_in;
    logic                 v1_reg;
    logic [2:0]           kind1_reg;
    logic signed [DW-1:0] ax1_reg, ay1_reg, aw1_reg, ah1_reg, bx1_reg, by1_reg, bw1_reg;
    logic signed [DW-1:0] lox_reg, hix_reg, loy_reg, hiy_reg;

    assign bx_in = DW'(in_item.b_x);
    assign by_in = DW'(in_item.b_y);
    assign bw_in = DW'(in_item.b_extent_x);
    assign bh_in = DW'(in_item.b_extent_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= in_item.kind;
            ax1_reg   <= DW'(in_item.a_x);
            ay1_reg   <= DW'(in_item.a_y);
            aw1_reg   <= DW'(in_item.a_extent_x);
            ah1_reg   <= DW'(in_item.a_extent_y);
            bx1_reg   <= bx_in;
            by1_reg   <= by_in;
            bw1_reg   <= bw_in;
            lox_reg   <= bx_in - bw_in;
            hix_reg   <= bx_in + bw_in;
            loy_reg   <= by_in - bh_in;
            hiy_reg   <= by_in + bh_in;
        end
    end

    // clamp and operand select
    logic signed [DW-1:0] cx, cy, ex, ey;
    logic                 in_box;
    logic                 isr_next, isb_next;
    logic signed [DW-1:0] dx_next, dy_next;
    logic [32:0]          reach_next;
    logic signed [DW-1:0] l_next, r_next, b_next, t_next;

    always_comb
    begin
        cx = (ax1_reg < lox_reg) ? lox_reg : ((ax1_reg > hix_reg) ? hix_reg : ax1_reg);
        cy = (ay1_reg < loy_reg) ? loy_reg : ((ay1_reg > hiy_reg) ? hiy_reg : ay1_reg);
        in_box     = (cx == ax1_reg) && (cy == ay1_reg);
        isr_next   = 1'b0;
        isb_next   = 1'b0;
        dx_next    = cx - ax1_reg;
        dy_next    = cy - ay1_reg;
        reach_next = 33'(aw1_reg);
        ex         = '0;
        ey         = '0;
        unique case (kind1_reg)
            KIND_POINT_CIRCLE:
            begin
                isr_next   = 1'b1;
                dx_next    = ax1_reg - bx1_reg;
                dy_next    = ay1_reg - by1_reg;
                reach_next = 33'(bw1_reg);
            end
            KIND_CIRCLE_CIRCLE:
            begin
                isr_next   = 1'b1;
                dx_next    = bx1_reg - ax1_reg;
                dy_next    = by1_reg - ay1_reg;
                reach_next = 33'(aw1_reg + bw1_reg);
            end
            KIND_POINT_BOX:
            begin
                isb_next = 1'b1;
            end
            KIND_BOX_BOX:
            begin
                isb_next = 1'b1;
                ex       = aw1_reg;
                ey       = ah1_reg;
            end
            KIND_CIRCLE_BOX:
            begin
                isr_next = !in_box;
                isb_next = in_box;
                ex       = aw1_reg;
                ey       = aw1_reg;
            end
            default:
            begin
                isr_next = 1'b0;
            end
        endcase
        l_next = (ax1_reg + ex) - lox_reg;
        r_next = hix_reg - (ax1_reg - ex);
        b_next = (ay1_reg + ey) - loy_reg;
        t_next = hiy_reg - (ay1_reg - ey);
    end

    logic                 v2_reg, isr2_reg, isb2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg, l2_reg, r2_reg, b2_reg, t2_reg;
    logic [32:0]          reach2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            isr2_reg   <= isr_next;
            isb2_reg   <= isb_next;
            dx2_reg    <= dx_next;
            dy2_reg    <= dy_next;
            reach2_reg <= reach_next;
            l2_reg     <= l_next;
            r2_reg     <= r_next;
            b2_reg     <= b_next;
            t2_reg     <= t_next;
        end
    end

    // magnitudes and box contact
    logic signed [DW-1:0] adx, ady, lr_min, bt_min, m;
    logic                 box_hit;
    tag_t                 tag_next;

    always_comb
    begin
        adx    = (dx2_reg < 0) ? -dx2_reg : dx2_reg;
        ady    = (dy2_reg < 0) ? -dy2_reg : dy2_reg;
        lr_min = (r2_reg < l2_reg) ? r2_reg : l2_reg;
        bt_min = (t2_reg < b2_reg) ? t2_reg : b2_reg;
        m      = (bt_min < lr_min) ? bt_min : lr_min;
        box_hit = isb2_reg && !(l2_reg < 0 || r2_reg < 0 || b2_reg < 0 || t2_reg < 0);
        tag_next.is_round = isr2_reg;
        tag_next.reach    = reach2_reg;
        tag_next.sx       = dx2_reg < 0;
        tag_next.sy       = dy2_reg < 0;
        tag_next.ux       = adx[UW-1:0];
        tag_next.uy       = ady[UW-1:0];
        tag_next.box      = '0;
        if (box_hit)
        begin
            tag_next.box.hit   = 1'b1;
            tag_next.box.depth = (|m[DW-1:32]) ? 32'hFFFF_FFFF : m[31:0];
            priority if (m == t2_reg)
                tag_next.box.normal_y = NORM_POS;
            else if (m == b2_reg)
                tag_next.box.normal_y = NORM_NEG;
            else if (m == r2_reg)
                tag_next.box.normal_x = NORM_POS;
            else
                tag_next.box.normal_x = NORM_NEG;
        end
    end

    logic v3_reg;
    tag_t tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tag3_reg <= tag_next;
    end

    assign out_valid = v3_reg;
    assign out_tag   = tag3_reg;
endmodule

### src/spc_square.sv
// squared length in three stages of split products
module spc_square import spc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tag_t          in_tag,
    output logic          out_valid,
    output tag_t          out_tag,
    output logic [SW-1:0] out_sum
);
    localparam int XHW = UW - HB;
    localparam int HHW = 2 * XHW;
    localparam int HLW = XHW + HB;
    localparam int LLW = 2 * HB;

    logic [XHW-1:0]       xh, yh;
    logic [HB-1:0]        xl, yl;
    logic                 v4_reg, v5_reg, v6_reg;
    tag_t                 tag4_reg, tag5_reg, tag6_reg;
    logic [HHW-1:0]       xhh_reg, yhh_reg;
    logic [HLW-1:0]       xhl_reg, yhl_reg;
    logic [LLW-1:0]       xll_reg, yll_reg;
    logic [SW-1:0]        xsq_reg, ysq_reg, sum_reg;

    assign xh = in_tag.ux[UW-1:HB];
    assign xl = in_tag.ux[HB-1:0];
    assign yh = in_tag.uy[UW-1:HB];
    assign yl = in_tag.uy[HB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag4_reg <= in_tag;
            xhh_reg  <= HHW'(xh) * HHW'(xh);
            xhl_reg  <= HLW'(xh) * HLW'(xl);
            xll_reg  <= LLW'(xl) * LLW'(xl);
            yhh_reg  <= HHW'(yh) * HHW'(yh);
            yhl_reg  <= HLW'(yh) * HLW'(yl);
            yll_reg  <= LLW'(yl) * LLW'(yl);
            tag5_reg <= tag4_reg;
            xsq_reg  <= (SW'(xhh_reg) << (2 * HB)) + (SW'(xhl_reg) << (HB + 1)) + SW'(xll_reg);
            ysq_reg  <= (SW'(yhh_reg) << (2 * HB)) + (SW'(yhl_reg) << (HB + 1)) + SW'(yll_reg);
            tag6_reg <= tag5_reg;
            sum_reg  <= xsq_reg + ysq_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_tag   = tag6_reg;
    assign out_sum   = sum_reg;
endmodule

### src/spc_sqrt.sv
// integer square root, one result bit per stage
module spc_sqrt import spc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tag_t          in_tag,
    input  logic [SW-1:0] in_sum,
    output logic          out_valid,
    output tag_t          out_tag,
    output logic [RW-1:0] out_root
);
    logic          v_reg    [RW];
    tag_t          tag_reg  [RW];
    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_step
            localparam int I = RW - 1 - k;
            logic          v_in;
            tag_t          tag_in;
            logic [SW-1:0] rem_in, trial;
            logic [RW-1:0] root_in;
            logic          take;

            if (k == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign tag_in  = in_tag;
                assign rem_in  = in_sum;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign v_in    = v_reg[k-1];
                assign tag_in  = tag_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign trial = (SW'(root_in) << (I + 1)) | (SW'(1) << (2 * I));
            assign take  = rem_in >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[k]  <= tag_in;
                    rem_reg[k]  <= take ? rem_in - trial : rem_in;
                    root_reg[k] <= take ? (root_in | (RW'(1) << I)) : root_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];
    assign out_root  = root_reg[RW-1];
endmodule

### src/spc_div.sv
// round hit test, normal division one quotient bit per stage, result select
module spc_div import spc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  tag_t          in_tag,
    input  logic [RW-1:0] in_len,
    output logic          out_valid,
    output contact_t      out_item
);
    typedef struct packed {
        logic          is_round;
        contact_t      box;
        logic          hit;
        logic [31:0]   depth;
        logic          sx;
        logic          sy;
        logic [RW-1:0] len;
    } dtag_t;

    dtag_t         tag0_next;
    logic          v0_reg;
    dtag_t         tag0_reg;
    logic [DV-1:0] rx0_reg, ry0_reg;

    always_comb
    begin
        tag0_next.is_round = in_tag.is_round;
        tag0_next.box      = in_tag.box;
        tag0_next.hit      = in_tag.is_round && (RW'(in_tag.reach) > in_len);
        tag0_next.depth    = 32'(RW'(in_tag.reach) - in_len);
        tag0_next.sx       = in_tag.sx;
        tag0_next.sy       = in_tag.sy;
        tag0_next.len      = in_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag0_reg <= tag0_next;
            rx0_reg  <= DV'(in_tag.ux) << (QW - 1);
            ry0_reg  <= DV'(in_tag.uy) << (QW - 1);
        end
    end

    logic          v_reg  [QW];
    dtag_t         tag_reg[QW];
    logic [DV-1:0] rx_reg [QW];
    logic [DV-1:0] ry_reg [QW];
    logic [QW-1:0] qx_reg [QW];
    logic [QW-1:0] qy_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            localparam int J = QW - 1 - k;
            logic          v_in;
            dtag_t         tag_in;
            logic [DV-1:0] rx_in, ry_in, dsh;
            logic [QW-1:0] qx_in, qy_in;
            logic          gx, gy;

            if (k == 0)
            begin : g_first
                assign v_in   = v0_reg;
                assign tag_in = tag0_reg;
                assign rx_in  = rx0_reg;
                assign ry_in  = ry0_reg;
                assign qx_in  = '0;
                assign qy_in  = '0;
            end
            else
            begin : g_next
                assign v_in   = v_reg[k-1];
                assign tag_in = tag_reg[k-1];
                assign rx_in  = rx_reg[k-1];
                assign ry_in  = ry_reg[k-1];
                assign qx_in  = qx_reg[k-1];
                assign qy_in  = qy_reg[k-1];
            end

            assign dsh = DV'(tag_in.len) << J;
            assign gx  = rx_in >= dsh;
            assign gy  = ry_in >= dsh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[k] <= tag_in;
                    rx_reg[k]  <= gx ? rx_in - dsh : rx_in;
                    ry_reg[k]  <= gy ? ry_in - dsh : ry_in;
                    qx_reg[k]  <= qx_in | (QW'(gx) << J);
                    qy_reg[k]  <= qy_in | (QW'(gy) << J);
                end
            end
        end
    endgenerate

    dtag_t              tl;
    logic signed [15:0] qxs, qys;
    logic               nz;
    contact_t           res_next;
    logic               vo_reg;
    contact_t           res_reg;

    always_comb
    begin
        tl  = tag_reg[QW-1];
        qxs = 16'(qx_reg[QW-1]);
        qys = 16'(qy_reg[QW-1]);
        nz  = tl.hit && (tl.len != '0);
        if (tl.is_round)
        begin
            res_next.hit      = tl.hit;
            res_next.normal_x = nz ? (tl.sx ? -qxs : qxs) : '0;
            res_next.normal_y = nz ? (tl.sy ? -qys : qys) : '0;
            res_next.depth    = tl.hit ? tl.depth : '0;
        end
        else
            res_next = tl.box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign out_item  = res_reg;
endmodule

### src/shape_pair_contact_2d_top.sv
// top level of the 2d shape pair contact block
// Takes one shape pair per cycle while the pipeline is not held and returns
// one contact result per pair, in order, through three front stages, three
// squaring stages, a 36-stage square root (one root bit per stage) and a
// 15-stage divider (one normal bit per stage) plus setup and result stages.
// All stages move together; when the result is not taken the whole pipeline
// holds, and ready follows that stall.
module shape_pair_contact_2d_top import spc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    spc_pair_if.sink      pair,
    spc_contact_if.source contact
);
    logic          en;
    logic          f_valid, q_valid, r_valid;
    tag_t          f_tag, q_tag, r_tag;
    logic [SW-1:0] q_sum;
    logic [RW-1:0] r_root;

    assign en         = !contact.valid || contact.ready;
    assign pair.ready = en;

    spc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair.valid),
        .in_item   (pair.item),
        .out_valid (f_valid),
        .out_tag   (f_tag)
    );

    spc_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_tag    (f_tag),
        .out_valid (q_valid),
        .out_tag   (q_tag),
        .out_sum   (q_sum)
    );

    spc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_tag    (q_tag),
        .in_sum    (q_sum),
        .out_valid (r_valid),
        .out_tag   (r_tag),
        .out_root  (r_root)
    );

    spc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_tag    (r_tag),
        .in_len    (r_root),
        .out_valid (contact.valid),
        .out_item  (contact.item)
    );

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pair.ready == (!contact.valid || contact.ready))
        else $error("input ready does not follow output stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        contact.valid && !contact.item.hit |->
            contact.item.normal_x == 16'sd0 && contact.item.normal_y == 16'sd0 &&
            contact.item.depth == 32'd0)
        else $error("miss with nonzero normal or depth");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        contact.valid |->
            contact.item.normal_x >= NORM_NEG && contact.item.normal_x <= NORM_POS &&
            contact.item.normal_y >= NORM_NEG && contact.item.normal_y <= NORM_POS)
        else $error("normal component out of unit range");
endmodule

### verif/tb.sv
// testbench for the 2d shape pair contact block: random and directed pairs, predicted contacts
module tb;
    import spc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class contact_ledger;
        contact_t pending[$];
        int       errors;
        int       hits;
        int       checked;

        function automatic contact_t round_contact(longint dx, longint dy, longint reach);
            contact_t    c;
            logic [71:0] wx;
            logic [71:0] wy;
            logic [71:0] sum;
            logic [71:0] trial;
            logic [35:0] root;
            longint      len;
            longint      d;
            longint      nx;
            longint      ny;
            c = '0;
            wx = (dx < 0) ? -dx : dx;
            wy = (dy < 0) ? -dy : dy;
            sum = wx * wx + wy * wy;
            root = '0;
            for (int i = 35; i >= 0; i--)
            begin
                trial = {36'b0, root | (36'b1 << i)};
                if (trial * trial <= sum)
                    root = trial[35:0];
            end
            len = longint'({28'b0, root});
            d = reach - len;
            if (d <= 0)
                return c;
            c.hit = 1'b1;
            if (len != 0)
            begin
                nx = dx * 16384 / len;
                ny = dy * 16384 / len;
                c.normal_x = nx[15:0];
                c.normal_y = ny[15:0];
            end
            c.depth = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
            return c;
        endfunction

        function automatic contact_t box_contact(longint ax, longint ay, longint aw,
                                                 longint ah, longint bx, longint by,
                                                 longint bw, longint bh);
            contact_t c;
            longint   l;
            longint   r;
            longint   b;
            longint   t;
            longint   m;
            c = '0;
            l = (ax + aw) - (bx - bw);
            r = (bx + bw) - (ax - aw);
            b = (ay + ah) - (by - bh);
            t = (by + bh) - (ay - ah);
            if (l < 0 || r < 0 || b < 0 || t < 0)
                return c;
            m = l;
            if (r < m) m = r;
            if (b < m) m = b;
            if (t < m) m = t;
            c.hit = 1'b1;
            if (m == t)
                c.normal_y = NORM_POS;
            else if (m == b)
                c.normal_y = NORM_NEG;
            else if (m == r)
                c.normal_x = NORM_POS;
            else
                c.normal_x = NORM_NEG;
            c.depth = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
            return c;
        endfunction

        function automatic contact_t contact_for(pair_t p);
            longint ax;
            longint ay;
            longint aw;
            longint ah;
            longint bx;
            longint by;
            longint bw;
            longint bh;
            longint cx;
            longint cy;
            ax = p.a_x;
            ay = p.a_y;
            aw = longint'({1'b0, p.a_extent_x});
            ah = longint'({1'b0, p.a_extent_y});
            bx = p.b_x;
            by = p.b_y;
            bw = longint'({1'b0, p.b_extent_x});
            bh = longint'({1'b0, p.b_extent_y});
            case (p.kind)
                KIND_POINT_CIRCLE:  return round_contact(ax - bx, ay - by, bw);
                KIND_CIRCLE_CIRCLE: return round_contact(bx - ax, by - ay, aw + bw);
                KIND_POINT_BOX:     return box_contact(ax, ay, 0, 0, bx, by, bw, bh);
                KIND_BOX_BOX:       return box_contact(ax, ay, aw, ah, bx, by, bw, bh);
                KIND_CIRCLE_BOX:
                begin
                    cx = ax;
                    cy = ay;
                    if (cx < bx - bw) cx = bx - bw;
                    if (cx > bx + bw) cx = bx + bw;
                    if (cy < by - bh) cy = by - bh;
                    if (cy > by + bh) cy = by + bh;
                    if (cx == ax && cy == ay)
                        return box_contact(ax, ay, aw, aw, bx, by, bw, bh);
                    return round_contact(cx - ax, cy - ay, aw);
                end
                default:            return '0;
            endcase
        endfunction

        function void note_pair(pair_t p);
            pending.push_back(contact_for(p));
        endfunction

        function void check_contact(contact_t got);
            contact_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected contact item %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.hit)
                hits++;
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.normal_x !== want.normal_x)
            begin
                $error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
                errors++;
            end
            if (got.normal_y !== want.normal_y)
            begin
                $error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
                errors++;
            end
            if (got.depth !== want.depth)
            begin
                $error("depth: expected %0d, got %0d", want.depth, got.depth);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   sent;

    spc_pair_if    pair_ch();
    spc_contact_if contact_ch();

    contact_ledger ledger = new();

    shape_pair_contact_2d_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (pair_ch),
        .contact (contact_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
        contact_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // handshakes are sampled mid-cycle, away from the driving edge
    always @(negedge clk)
    begin
        if (rst_n && pair_ch.valid && pair_ch.ready)
            ledger.note_pair(pair_ch.item);
        if (rst_n && contact_ch.valid && contact_ch.ready)
            ledger.check_contact(contact_ch.item);
    end

    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.item  <= p;
        do
            @(negedge clk);
        while (!pair_ch.ready);
        @(posedge clk);
        sent++;
    endtask

    function automatic logic [31:0] rand_coord(int scale);
        logic [31:0] v;
        v = $urandom;
        return $signed(v) >>> scale;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    scale;
        p.kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        if ($urandom_range(9) < 2)
        begin
            p.a_x = $urandom;
            p.a_y = $urandom;
            p.b_x = $urandom;
            p.b_y = $urandom;
            p.a_extent_x = 31'($urandom);
            p.a_extent_y = 31'($urandom);
            p.b_extent_x = 31'($urandom);
            p.b_extent_y = 31'($urandom);
        end
        else
        begin
            scale = $urandom_range(30, 1);
            p.b_x = rand_coord(1);
            p.b_y = rand_coord(1);
            p.a_x = p.b_x + rand_coord(scale);
            p.a_y = p.b_y + rand_coord(scale);
            p.a_extent_x = 31'($urandom) >> scale;
            p.a_extent_y = 31'($urandom) >> scale;
            p.b_extent_x = 31'($urandom) >> scale;
            p.b_extent_y = 31'($urandom) >> scale;
            if ($urandom_range(3) == 0)
            begin
                p.a_x = p.b_x;
                p.a_y = p.b_y;
            end
            if ($urandom_range(5) == 0)
                p.a_extent_y = p.a_extent_x;
        end
        return p;
    endfunction

    function automatic pair_t make_pair(logic [2:0] k, int ax, int ay, int aw, int ah,
                                        int bx, int by, int bw, int bh);
        pair_t p;
        p.kind = k;
        p.a_x = ax;
        p.a_y = ay;
        p.a_extent_x = 31'(aw);
        p.a_extent_y = 31'(ah);
        p.b_x = bx;
        p.b_y = by;
        p.b_extent_x = 31'(bw);
        p.b_extent_y = 31'(bh);
        return p;
    endfunction

    initial
    begin
        pair_t directed[$];
        int    total;
        int    settle;
        rst_n = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 73;
        sent = 0;
        pair_ch.valid = 1'b0;
        pair_ch.item = '0;
        contact_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_pair(KIND_POINT_CIRCLE, 0, 0, 0, 0, 0, 0, 32'h10000, 0));
        directed.push_back(make_pair(KIND_POINT_CIRCLE, 3 << 16, 4 << 16, 0, 0, 0, 0,
                                     6 << 16, 0));
        directed.push_back(make_pair(KIND_POINT_CIRCLE, 5 << 16, 0, 0, 0, 0, 0, 5 << 16, 0));
        directed.push_back(make_pair(KIND_CIRCLE_CIRCLE, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(KIND_CIRCLE_CIRCLE, 32'h80000000, 32'h80000000,
                                     32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 0));
        directed.push_back(make_pair(KIND_CIRCLE_CIRCLE, -100, 50, 200, 0, 100, -50, 200, 0));
        directed.push_back(make_pair(KIND_POINT_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(KIND_POINT_BOX, 10, 0, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_POINT_BOX, 11, 0, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_POINT_BOX, 0, 3, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_POINT_BOX, 0, -3, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_POINT_BOX, 3, 0, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_POINT_BOX, -3, 0, 0, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_BOX_BOX, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(KIND_BOX_BOX, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,
                                     32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(KIND_BOX_BOX, 30, 0, 10, 10, 0, 0, 20, 20));
        directed.push_back(make_pair(KIND_BOX_BOX, 31, 0, 10, 10, 0, 0, 20, 20));
        directed.push_back(make_pair(KIND_CIRCLE_BOX, 0, 0, 5, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_CIRCLE_BOX, 14, 0, 5, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_CIRCLE_BOX, 13, 14, 5, 0, 0, 0, 10, 10));
        directed.push_back(make_pair(KIND_CIRCLE_BOX, 32'h7FFFFFFF, 32'h80000000,
                                     32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(3'd5, 0, 0, 5, 5, 0, 0, 5, 5));
        directed.push_back(make_pair(3'd7, -1, -1, 32'h7FFFFFFF, 32'h7FFFFFFF, -1, -1,
                                     32'h7FFFFFFF, 32'h7FFFFFFF));
        foreach (directed[i])
            send_pair(directed[i]);

        total = 1500;
        for (int n = 0; n < total; n++)
        begin
            if (n == total / 3)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 18;
            end
            else if (n == 2 * total / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pair(random_pair());
        end
        pair_ch.valid <= 1'b0;

        while (ledger.pending.size() != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 80)
        begin
            @(posedge clk);
            settle++;
        end

        $display("%0d shape pairs sent, %0d contacts checked, %0d of them hits",
                 sent, ledger.checked, ledger.hits);
        if (ledger.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("timeout with %0d contacts outstanding", ledger.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
